/* hw/rtl/dtpb_pkg.sv */
// Shared types, constants and a helper function for the depth-tested pixel buffer.
package dtpb_pkg;

  localparam int FRAME_WIDTH_DEF  = 64;
  localparam int FRAME_HEIGHT_DEF = 32;

  localparam int DEPTH_W     = 16;
  localparam int INTENSITY_W = 8;
  localparam int SHADE_W     = 3;
  localparam int FUNC_W      = 2;

  localparam logic signed [DEPTH_W-1:0] CLEAR_DEPTH_RESET = 16'sd2560;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PLOT   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  localparam logic [SHADE_W-1:0] SHADE_BLANK = 3'd0;
  localparam logic [SHADE_W-1:0] SHADE_DIM   = 3'd1;
  localparam logic [SHADE_W-1:0] SHADE_LOW   = 3'd2;
  localparam logic [SHADE_W-1:0] SHADE_MID   = 3'd3;
  localparam logic [SHADE_W-1:0] SHADE_FULL  = 3'd4;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic signed [15:0]        pos_x;
    logic signed [15:0]        pos_y;
    logic signed [DEPTH_W-1:0] depth;
    logic [INTENSITY_W-1:0]    intensity;
  } in_item_t;

  typedef struct packed {
    logic               accepted;
    logic [SHADE_W-1:0] shade;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SWEEP,
    ST_RESOLVE
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic sweep_arm;
    logic sweep_wr;
    logic mem_rd;
    logic resolve;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic              sweep_last;
    logic              slot_free;
  } dp_status_t;

  // Quantize an intensity into one of five shade levels split at quarters.
  function automatic logic [SHADE_W-1:0] shade_of(input logic [INTENSITY_W-1:0] c);
    logic [SHADE_W-1:0] s;
    begin
      case (c[7:6])
        2'b00:   s = (c == '0) ? SHADE_BLANK : SHADE_DIM;
        2'b01:   s = SHADE_LOW;
        2'b10:   s = SHADE_MID;
        2'b11:   s = SHADE_FULL;
        default: s = SHADE_BLANK;
      endcase
      return s;
    end
  endfunction

endpackage

/* hw/rtl/dtpb_ctrl.sv */
// Controller state machine that sequences item lookups, store sweeps and result hand-off.
module dtpb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtpb_pkg::in_item_t  in_data,
  input  dtpb_pkg::dp_status_t status,
  output dtpb_pkg::dp_cmd_t   cmd
);
  import dtpb_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT: begin
        if (status.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_data.func == FUNC_CLEAR) ? ST_SWEEP : ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_RESOLVE;
      end
      ST_SWEEP: begin
        if (status.sweep_last) begin
          state_nxt = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (status.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_INIT: begin
        cmd.sweep_wr = 1'b1;
      end
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_item = in_valid;
        cmd.sweep_arm = in_valid && (in_data.func == FUNC_CLEAR);
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      ST_SWEEP: begin
        cmd.sweep_wr = 1'b1;
      end
      ST_RESOLVE: begin
        cmd.resolve = status.slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* hw/rtl/dtpb_dp.sv */
// Datapath: pixel store memory, item registers, depth test, clear sweep and result register.
module dtpb_dp #(
  parameter int FRAME_WIDTH  = dtpb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dtpb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dtpb_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output dtpb_pkg::out_item_t         out_data,
  input  logic                        cfg_write_en,
  input  logic signed [15:0]          cfg_wdata,
  input  dtpb_pkg::dp_cmd_t           cmd,
  output dtpb_pkg::dp_status_t        status
);
  import dtpb_pkg::*;

  localparam int STORE_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
  localparam int AW         = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int WORD_W     = DEPTH_W + INTENSITY_W;

  // Each word holds the depth in the upper bits and the intensity below it.
  logic [WORD_W-1:0] mem [STORE_SIZE];

  logic signed [DEPTH_W-1:0] clear_depth_r;
  logic signed [DEPTH_W-1:0] sweep_depth_r;
  logic [AW-1:0]             cnt_r;

  logic [FUNC_W-1:0]         func_r;
  logic [AW-1:0]             idx_r;
  logic                      in_range_r;
  logic signed [DEPTH_W-1:0] depth_r;
  logic [INTENSITY_W-1:0]    intensity_r;

  logic [WORD_W-1:0]         rd_r;
  out_item_t                 out_r;
  logic                      out_valid_r;

  logic                      x_ok;
  logic                      y_ok;
  logic                      in_range;
  logic [AW-1:0]             idx;
  logic                      slot_free;
  logic                      plot_win;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [WORD_W-1:0]         mem_wdata;
  out_item_t                 result;

  assign x_ok = !in_data.pos_x[15] && ({1'b0, in_data.pos_x[14:0]} < 16'(FRAME_WIDTH));
  assign y_ok = !in_data.pos_y[15] && ({1'b0, in_data.pos_y[14:0]} < 16'(FRAME_HEIGHT));
  assign in_range = x_ok && y_ok;

  // Row-major address; forced to zero when the pixel lies outside the frame.
  assign idx = in_range
             ? AW'(32'(in_data.pos_y[14:0]) * 32'(FRAME_WIDTH) + 32'(in_data.pos_x[14:0]))
             : '0;

  assign slot_free = !out_valid_r || !out_stall;
  assign plot_win  = in_range_r && ($signed(rd_r[WORD_W-1:INTENSITY_W]) > depth_r);

  always_comb begin
    result = '0;
    case (func_r)
      FUNC_CLEAR: begin
        result.accepted = 1'b1;
      end
      FUNC_PLOT: begin
        result.accepted = plot_win;
      end
      FUNC_READ: begin
        result.accepted = in_range_r;
        result.shade    = in_range_r ? shade_of(rd_r[INTENSITY_W-1:0]) : SHADE_BLANK;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.sweep_wr) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_r;
      mem_wdata = {sweep_depth_r, {INTENSITY_W{1'b0}}};
    end else begin
      mem_we    = cmd.resolve && (func_r == FUNC_PLOT) && plot_win;
      mem_waddr = idx_r;
      mem_wdata = {depth_r, intensity_r};
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_r <= mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      func_r      <= in_data.func;
      idx_r       <= idx;
      in_range_r  <= in_range;
      depth_r     <= in_data.depth;
      intensity_r <= in_data.intensity;
    end
    if (cmd.resolve) begin
      out_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_depth_r <= CLEAR_DEPTH_RESET;
      sweep_depth_r <= CLEAR_DEPTH_RESET;
      cnt_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        clear_depth_r <= cfg_wdata;
      end
      if (cmd.sweep_arm) begin
        sweep_depth_r <= clear_depth_r;
        cnt_r         <= '0;
      end else if (cmd.sweep_wr) begin
        cnt_r <= (cnt_r == AW'(STORE_SIZE - 1)) ? '0 : cnt_r + 1'b1;
      end
      if (cmd.resolve) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign status.sweep_last = (cnt_r == AW'(STORE_SIZE - 1));
  assign status.slot_free  = slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

/* hw/rtl/depth_tested_pixel_buffer.sv */
// Depth-tested frame store: a plot, read or clear item in, one result beat out.
// Plot, read and unused items pass through ST_READ and then ST_RESOLVE before the result beat.
// A clear item sweeps the store one entry per cycle, then passes to ST_RESOLVE.
// A new item is taken only once the previous item's result has been loaded into the result register.
// After reset the store is swept, entry by entry, to depth 10.0 and intensity 0,
// with in_stall high; configuration writes are taken throughout.
module depth_tested_pixel_buffer #(
  parameter int FRAME_WIDTH  = dtpb_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = dtpb_pkg::FRAME_HEIGHT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dtpb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dtpb_pkg::out_item_t out_data,
  input  logic                cfg_write_en,
  input  logic signed [15:0]  cfg_wdata
);
  import dtpb_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dtpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .status   (status),
    .cmd      (cmd)
  );

  dtpb_dp #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .status       (status)
  );

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the depth-tested pixel buffer: driver, monitor and pixel-store mirror.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dtpb_pkg::*;

  localparam int FW = FRAME_WIDTH_DEF;
  localparam int FH = FRAME_HEIGHT_DEF;
  localparam int PIXELS = FW * FH;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 112;
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_write_en = 1'b0;
  logic signed [15:0] cfg_wdata = '0;

  // Mirror of the pixel store and of the clear depth register.
  logic signed [DEPTH_W-1:0] z_mirror [PIXELS];
  logic [INTENSITY_W-1:0] lum_mirror [PIXELS];
  logic signed [DEPTH_W-1:0] clear_z;

  in_item_t item_backlog[$];
  out_item_t awaited_results[$];

  int items_queued = 0;
  int results_checked = 0;
  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int phase_idx = -1;
  logic long_hold = 1'b0;

  int clears_seen = 0;
  int plots_written = 0;
  int plots_refused = 0;
  int reads_done = 0;
  int odd_codes = 0;
  int depth_settings = 0;

  depth_tested_pixel_buffer u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_wdata    (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [SHADE_W-1:0] shade_level(input logic [INTENSITY_W-1:0] lum);
    begin
      if (lum == 0) return SHADE_BLANK;
      if (lum < 64) return SHADE_DIM;
      if (lum < 128) return SHADE_LOW;
      if (lum < 192) return SHADE_MID;
      return SHADE_FULL;
    end
  endfunction

  // Applies one accepted item to the mirror and records the result it must produce.
  task automatic apply_pixel_op(input in_item_t it);
    int px;
    int py;
    int nz;
    int oz;
    int slot;
    bit in_frame;
    out_item_t res;
    begin
      res = '0;
      px = $signed(it.pos_x);
      py = $signed(it.pos_y);
      nz = $signed(it.depth);
      in_frame = (px >= 0) && (px < FW) && (py >= 0) && (py < FH);
      slot = in_frame ? py * FW + px : 0;
      case (it.func)
        FUNC_CLEAR: begin
          for (int i = 0; i < PIXELS; i++) begin
            z_mirror[i] = clear_z;
            lum_mirror[i] = '0;
          end
          res.accepted = 1'b1;
          clears_seen++;
        end
        FUNC_PLOT: begin
          oz = z_mirror[slot];
          if (in_frame && oz > nz) begin
            z_mirror[slot] = it.depth;
            lum_mirror[slot] = it.intensity;
            res.accepted = 1'b1;
            plots_written++;
          end else begin
            plots_refused++;
          end
        end
        FUNC_READ: begin
          if (in_frame) begin
            res.accepted = 1'b1;
            res.shade = shade_level(lum_mirror[slot]);
          end
          reads_done++;
        end
        default: begin
          odd_codes++;
        end
      endcase
      awaited_results.push_back(res);
    end
  endtask

  function automatic in_item_t make_op(input logic [FUNC_W-1:0] func, input int x, input int y,
                                       input int z, input int lum);
    in_item_t it;
    begin
      it.func = func;
      it.pos_x = 16'(x);
      it.pos_y = 16'(y);
      it.depth = 16'(z);
      it.intensity = 8'(lum);
      return it;
    end
  endfunction

  // Coordinates cluster on a small corner so that plots and reads keep meeting the same pixels.
  function automatic logic [15:0] pick_coord(input int span);
    int pick;
    begin
      pick = $urandom_range(99);
      if (pick < 45) return 16'($urandom_range(span / 8 - 1));
      if (pick < 80) return 16'($urandom_range(span - 1));
      if (pick < 90) begin
        case ($urandom_range(5))
          0: return 16'hFFFF;
          1: return 16'h0000;
          2: return 16'(span - 1);
          3: return 16'(span);
          4: return 16'h8000;
          default: return 16'h7FFF;
        endcase
      end
      return 16'($urandom);
    end
  endfunction

  function automatic in_item_t random_pixel_op();
    in_item_t it;
    int pick;
    begin
      pick = $urandom_range(99);
      if (pick < 2) it.func = FUNC_CLEAR;
      else if (pick < 4) it.func = FUNC_UNUSED;
      else if (pick < 52) it.func = FUNC_PLOT;
      else it.func = FUNC_READ;
      it.pos_x = pick_coord(FW);
      it.pos_y = pick_coord(FH);
      if ($urandom_range(99) < 40) it.depth = 16'($urandom);
      else it.depth = 16'(clear_z - $urandom_range(512) + 64);
      if ($urandom_range(99) < 10) it.intensity = '0;
      else it.intensity = 8'($urandom);
      return it;
    end
  endfunction

  task automatic queue_item(input in_item_t it);
    begin
      item_backlog.push_back(it);
      items_queued++;
    end
  endtask

  task automatic wait_drained();
    begin
      while (results_checked < items_queued) @(posedge clk);
    end
  endtask

  task automatic write_clear_depth(input logic signed [15:0] value);
    begin
      @(posedge clk);
      cfg_write_en <= 1'b1;
      cfg_wdata <= value;
      @(posedge clk);
      cfg_write_en <= 1'b0;
      clear_z = value;
      depth_settings++;
    end
  endtask

  // Driver: offers the next pending beat and holds it until the block takes it.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) apply_pixel_op(in_data);
      if (!in_valid || !in_stall) begin
        if (item_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= item_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction and drives out_stall.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (awaited_results.size() == 0) begin
          $display("%0t: result beat with nothing expected: accepted=%0b shade=%0d",
                   $time, out_data.accepted, out_data.shade);
          err_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_data.accepted !== want.accepted) begin
            $display("%0t: accepted mismatch: expected %0b, got %0b",
                     $time, want.accepted, out_data.accepted);
            err_count++;
          end
          if (out_data.shade !== want.shade) begin
            $display("%0t: shade mismatch: expected %0d, got %0d",
                     $time, want.shade, out_data.shade);
            err_count++;
          end
        end
      end
      out_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // A long receiver hold while the sender keeps offering, so the block backs up.
  // The hold starts once the phase's opening clear has swept the whole store.
  initial begin
    while (phase_idx != 1) @(posedge clk);
    repeat (PIXELS + 40) @(posedge clk);
    long_hold <= 1'b1;
    repeat (500) @(posedge clk);
    long_hold <= 1'b0;
  end

  initial begin
    #4ms;
    $display("depth_tested_pixel_buffer test failed");
    $finish;
  end

  initial begin
    logic signed [15:0] phase_depth [PHASES];
    clear_z = CLEAR_DEPTH_RESET;
    for (int i = 0; i < PIXELS; i++) begin
      z_mirror[i] = CLEAR_DEPTH_RESET;
      lum_mirror[i] = '0;
    end
    phase_depth[0] = 16'sh7FFF;
    phase_depth[1] = 16'sh8000;
    phase_depth[2] = 16'($urandom);
    phase_depth[3] = 16'sh0000;
    phase_depth[4] = 16'($urandom);
    phase_depth[5] = CLEAR_DEPTH_RESET;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 35;
    recv_idle_pct = 80;

    // Directed beats on the store as left by reset.
    queue_item(make_op(FUNC_READ, 0, 0, 0, 0));
    queue_item(make_op(FUNC_PLOT, 0, 0, 2559, 255));
    queue_item(make_op(FUNC_PLOT, 0, 0, 2559, 7));      // equal depth is not nearer
    queue_item(make_op(FUNC_PLOT, 0, 0, 32767, 9));
    queue_item(make_op(FUNC_PLOT, FW - 1, FH - 1, -32768, 1));
    queue_item(make_op(FUNC_PLOT, FW, 0, 0, 50));
    queue_item(make_op(FUNC_PLOT, -1, 0, 0, 50));
    queue_item(make_op(FUNC_PLOT, 0, FH, 0, 50));
    queue_item(make_op(FUNC_PLOT, 32767, -32768, 0, 50));
    queue_item(make_op(FUNC_PLOT, -32768, 32767, 0, 50));
    queue_item(make_op(FUNC_PLOT, 1, 0, 0, 63));
    queue_item(make_op(FUNC_PLOT, 2, 0, 0, 64));
    queue_item(make_op(FUNC_PLOT, 3, 0, 0, 128));
    queue_item(make_op(FUNC_PLOT, 4, 0, 0, 192));
    queue_item(make_op(FUNC_PLOT, 5, 0, -1, 191));
    for (int x = 0; x <= 5; x++) queue_item(make_op(FUNC_READ, x, 0, 0, 0));
    queue_item(make_op(FUNC_READ, FW - 1, FH - 1, 0, 0));
    queue_item(make_op(FUNC_READ, FW, 0, 0, 0));
    queue_item(make_op(FUNC_READ, 0, -1, 0, 0));
    queue_item(make_op(FUNC_UNUSED, 0, 0, -32768, 255));
    queue_item(make_op(FUNC_CLEAR, 0, 0, 0, 0));
    queue_item(make_op(FUNC_READ, 0, 0, 0, 0));
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      phase_idx = p;
      if (p < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 80;
      end else if (p < 4) begin
        send_idle_pct = 80;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_clear_depth(phase_depth[p]);
      queue_item(make_op(FUNC_CLEAR, 0, 0, 0, 0));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Midway the sender stops until every pending result has come back.
        if (n == PHASE_ITEMS / 2) wait_drained();
        queue_item(random_pixel_op());
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, awaited_results.size());
      err_count++;
    end
    $display("Ran %0d beats: %0d clears, %0d plots written, %0d refused, %0d reads, %0d unused.",
             items_queued, clears_seen, plots_written, plots_refused, reads_done, odd_codes);
    $display("Clear depth was set %0d times, including both signed extremes.", depth_settings);
    if (err_count == 0) begin
      $display("depth_tested_pixel_buffer test passed");
    end else begin
      $display("depth_tested_pixel_buffer test failed");
    end
    $finish;
  end

endmodule
